@@ rtl/core/noise_floor_power_squelch_defines.svh @@
// Assertion macros for the noise floor power squelch.
// Included by the top level only; no other dependencies.
`ifndef NOISE_FLOOR_POWER_SQUELCH_DEFINES_SVH
`define NOISE_FLOOR_POWER_SQUELCH_DEFINES_SVH

`ifndef SYNTH

// condition must never be seen outside reset
`define NFPS_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("squelch check failed: forbidden condition seen");

// antecedent on a cycle forces the consequent in the following cycle
`define NFPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("squelch check failed: expected follow-up not seen");

// antecedent forces the consequent in the same cycle
`define NFPS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("squelch check failed: implication broken");

`else

`define NFPS_ASSERT_NEVER(lbl, clk, rst, cond)
`define NFPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define NFPS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/nfps_pkg.sv @@
// Shared types and constants for the noise floor power squelch.
// No dependencies; used by every module of the block except nfps_fifo.
package nfps_pkg;

   // default datapath geometry
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   // shared multiplier: a chunk of the wide operand times the narrow one
   localparam int CHUNK_W     = 24;
   localparam int FACTOR_W    = 24;
   localparam int FACTOR_FRAC = 8;
   localparam int ALPHA_W     = 17;
   localparam int ALPHA_FRAC  = 16;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
   localparam int COUNT_W     = 16;

   // queue depths
   localparam int IQ_DEPTH = 4;
   localparam int OQ_DEPTH = 4;

   // register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] REG_SMOOTHING    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REL_FACTOR   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TAIL_LENGTH  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE_COUNT = 2'd3;

   localparam logic [ALPHA_W-1:0]  SMOOTHING_RST    = 17'd655;
   localparam logic [FACTOR_W-1:0] REL_FACTOR_RST   = 24'd2560;
   localparam logic [COUNT_W-1:0]  TAIL_LENGTH_RST  = 16'd16;
   localparam logic [COUNT_W-1:0]  SETTLE_COUNT_RST = 16'd100;

   // result kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_MARKER = 1'b1;

   typedef struct packed {
      logic [ALPHA_W-1:0]  smoothing;
      logic [FACTOR_W-1:0] rel_factor;
      logic [COUNT_W-1:0]  tail_length;
      logic                load_settle;
      logic [COUNT_W-1:0]  settle_value;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FMUL,
      ST_FUPD,
      ST_FLOOR,
      ST_TMUL,
      ST_DECIDE,
      ST_SECOND
   } state_type;

endpackage

@@ rtl/core/nfps_fifo.sv @@
// Small first-in first-out queue built from a register array.
// Uses no package items; instantiated twice by the top level.
module nfps_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write the beat into storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/core/nfps_front.sv @@
// Front end: accepts samples and forms instantaneous power I*I+Q*Q.
// Two register stages (magnitude, squares) feeding the work queue.
module nfps_front #(
   parameter int SAMPLE_BITS = nfps_pkg::SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic signed [SAMPLE_BITS-1:0] in_i,
   input  logic signed [SAMPLE_BITS-1:0] in_q,
   input  logic                       q_full,
   output logic                       q_push,
   output logic [4*SAMPLE_BITS-1:0]   q_wdata
);

   localparam int SB = SAMPLE_BITS;
   localparam int SW = 2 * SAMPLE_BITS;

   logic          a_valid_ff, a_valid_in;
   logic [SB-1:0] a_i_ff, a_i_in, a_q_ff, a_q_in;
   logic [SB-1:0] a_mi_ff, a_mi_in, a_mq_ff, a_mq_in;
   logic          b_valid_ff, b_valid_in;
   logic [SB-1:0] b_i_ff, b_i_in, b_q_ff, b_q_in;
   logic [SW-1:0] b_si_ff, b_si_in, b_sq_ff, b_sq_in;
   logic [SB-1:0] raw_i, raw_q;
   logic          a_adv, b_adv;
   logic [SW-1:0] power;

   assign raw_i = in_i;
   assign raw_q = in_q;

   // stage enables: a stage moves when it is empty or its successor moves
   assign b_adv = !b_valid_ff || !q_full;
   assign a_adv = !a_valid_ff || b_adv;
   assign full  = !a_adv;

   // stage A: hold sample, take magnitudes (most negative code maps to itself)
   always_comb begin
      a_valid_in = a_valid_ff;
      a_i_in     = a_i_ff;
      a_q_in     = a_q_ff;
      a_mi_in    = a_mi_ff;
      a_mq_in    = a_mq_ff;
      if (a_adv) begin
         a_valid_in = push;
         a_i_in     = raw_i;
         a_q_in     = raw_q;
         a_mi_in    = raw_i[SB-1] ? (~raw_i + 1'b1) : raw_i;
         a_mq_in    = raw_q[SB-1] ? (~raw_q + 1'b1) : raw_q;
      end
   end

   // stage B: squares, one multiplier per rail
   always_comb begin
      b_valid_in = b_valid_ff;
      b_i_in     = b_i_ff;
      b_q_in     = b_q_ff;
      b_si_in    = b_si_ff;
      b_sq_in    = b_sq_ff;
      if (b_adv) begin
         b_valid_in = a_valid_ff;
         b_i_in     = a_i_ff;
         b_q_in     = a_q_ff;
         b_si_in    = SW'(a_mi_ff) * SW'(a_mi_ff);
         b_sq_in    = SW'(a_mq_ff) * SW'(a_mq_ff);
      end
   end

   // sum of squares cannot exceed 2^(SW-1)
   assign power   = b_si_ff + b_sq_ff;
   assign q_push  = b_valid_ff && !q_full;
   assign q_wdata = {b_i_ff, b_q_ff, power};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_i_ff  <= a_i_in;
      a_q_ff  <= a_q_in;
      a_mi_ff <= a_mi_in;
      a_mq_ff <= a_mq_in;
      b_i_ff  <= b_i_in;
      b_q_ff  <= b_q_in;
      b_si_ff <= b_si_in;
      b_sq_ff <= b_sq_in;
   end

endmodule

@@ rtl/core/nfps_back.sv @@
// Back end: smoothing filter, noise floor tracking and gate sequencer.
// Uses nfps_pkg; one shared chunked multiplier serves filter and threshold.
module nfps_back #(
   parameter int SAMPLE_BITS = nfps_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = nfps_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  nfps_pkg::cfg_type                      cfg,
   input  logic                                   iq_empty,
   input  logic [4*SAMPLE_BITS-1:0]               iq_rdata,
   output logic                                   iq_pop,
   input  logic [$clog2(nfps_pkg::OQ_DEPTH+1)-1:0] oq_count,
   output logic                                   oq_push,
   output logic [4*SAMPLE_BITS+3-1:0]             oq_wdata
);

   localparam int SB     = SAMPLE_BITS;
   localparam int SW     = 2 * SAMPLE_BITS;
   localparam int PB     = SW + FRAC_BITS;
   localparam int CW     = nfps_pkg::CHUNK_W;
   localparam int FW     = nfps_pkg::FACTOR_W;
   localparam int NCHUNK = (PB + CW - 1) / CW;
   localparam int OPA_W  = NCHUNK * CW;
   localparam int PROD_W = CW + FW;
   localparam int ACC_W  = OPA_W + FW;
   localparam int CNT_W  = $clog2(NCHUNK + 1);
   localparam int OQC_W  = $clog2(nfps_pkg::OQ_DEPTH + 1);
   localparam int TW     = nfps_pkg::COUNT_W;
   localparam logic [PB-1:0] FULL_SCALE = PB'(1) << (SW - 2 + FRAC_BITS);

   nfps_pkg::state_type st_ff, st_in;

   logic [PB-1:0]     avg_ff, avg_in;
   logic [PB-1:0]     floor_ff, floor_in;
   logic              gate_ff, gate_in;
   logic [TW-1:0]     settle_ff, settle_in;
   logic [TW-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [OPA_W-1:0]  opa_ff, opa_in;
   logic [FW-1:0]     b_ff, b_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              up_ff, up_in;
   logic [SB-1:0]     i_ff, i_in, q_ff, q_in;

   logic [SB-1:0]     head_i, head_q;
   logic [PB-1:0]     head_x, diff, step, floor_new, thr;
   logic [nfps_pkg::ALPHA_W-1:0] alpha;
   logic [CW-1:0]     chunk;
   logic [SW-1:0]     level;
   logic              go, mul_done, up_now, sat, close_now, open_now, two_out;

   // unpack the queue head; power gains its fraction bits here
   assign head_i = iq_rdata[4*SB-1 -: SB];
   assign head_q = iq_rdata[3*SB-1 -: SB];
   assign head_x = {iq_rdata[SW-1:0], {FRAC_BITS{1'b0}}};

   assign go       = !iq_empty && (oq_count <= OQC_W'(nfps_pkg::OQ_DEPTH - 2));
   assign mul_done = (cnt_ff == CNT_W'(NCHUNK));

   // clamp alpha to one
   assign alpha = cfg.smoothing[nfps_pkg::ALPHA_W-1] ? nfps_pkg::ALPHA_ONE : cfg.smoothing;

   // filter direction and distance
   assign up_now = (head_x >= avg_ff);
   assign diff   = up_now ? (head_x - avg_ff) : (avg_ff - head_x);
   assign step   = acc_ff[nfps_pkg::ALPHA_FRAC +: PB];

   // floor tracking after the settle count runs out
   assign floor_new = (settle_ff == '0 && avg_ff < floor_ff) ? avg_ff : floor_ff;

   // shared multiplier, top chunk first
   assign chunk = opa_ff[OPA_W-1 -: CW];

   // threshold with saturation, gate decision
   always_comb begin
      sat       = |acc_ff[ACC_W-1:PB+nfps_pkg::FACTOR_FRAC];
      thr       = sat ? {PB{1'b1}} : acc_ff[nfps_pkg::FACTOR_FRAC +: PB];
      close_now = gate_ff && (avg_ff < thr);
      open_now  = !gate_ff && (avg_ff >= thr);
      two_out   = close_now && (cfg.tail_length != '0);
   end

   assign level = avg_ff[FRAC_BITS +: SW];

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         nfps_pkg::ST_IDLE: begin
            if (go) st_in = nfps_pkg::ST_FMUL;
         end
         nfps_pkg::ST_FMUL: begin
            if (mul_done) st_in = nfps_pkg::ST_FUPD;
         end
         nfps_pkg::ST_FUPD:  st_in = nfps_pkg::ST_FLOOR;
         nfps_pkg::ST_FLOOR: st_in = nfps_pkg::ST_TMUL;
         nfps_pkg::ST_TMUL: begin
            if (mul_done) st_in = nfps_pkg::ST_DECIDE;
         end
         nfps_pkg::ST_DECIDE: begin
            st_in = two_out ? nfps_pkg::ST_SECOND : nfps_pkg::ST_IDLE;
         end
         nfps_pkg::ST_SECOND: st_in = nfps_pkg::ST_IDLE;
         default:             st_in = nfps_pkg::ST_IDLE;
      endcase
   end

   // queue handshakes and result beats
   always_comb begin
      iq_pop   = 1'b0;
      oq_push  = 1'b0;
      oq_wdata = {nfps_pkg::KIND_SAMPLE, {SB{1'b0}}, {SB{1'b0}}, 1'b0, level, 1'b1};
      case (st_ff)
         nfps_pkg::ST_IDLE: iq_pop = go;
         nfps_pkg::ST_DECIDE: begin
            if (close_now) begin
               oq_push  = 1'b1;
               oq_wdata = {nfps_pkg::KIND_MARKER, {SB{1'b0}}, {SB{1'b0}}, 1'b0, level,
                           !two_out};
            end else if (open_now) begin
               oq_push  = 1'b1;
               oq_wdata = {nfps_pkg::KIND_SAMPLE, i_ff, q_ff, 1'b1, level, 1'b1};
            end else if (gate_ff) begin
               oq_push  = 1'b1;
               oq_wdata = {nfps_pkg::KIND_SAMPLE, i_ff, q_ff, 1'b0, level, 1'b1};
            end else if (tail_ff != '0) begin
               oq_push  = 1'b1;
            end
         end
         nfps_pkg::ST_SECOND: oq_push = 1'b1;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      avg_in    = avg_ff;
      floor_in  = floor_ff;
      gate_in   = gate_ff;
      settle_in = settle_ff;
      tail_in   = tail_ff;
      cnt_in    = cnt_ff;
      opa_in    = opa_ff;
      b_in      = b_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      up_in     = up_ff;
      i_in      = i_ff;
      q_in      = q_ff;
      case (st_ff)
         nfps_pkg::ST_IDLE: begin
            if (go) begin
               up_in  = up_now;
               opa_in = OPA_W'(diff);
               b_in   = FW'(alpha);
               cnt_in = '0;
               i_in   = head_i;
               q_in   = head_q;
            end
         end
         nfps_pkg::ST_FMUL, nfps_pkg::ST_TMUL: begin
            prod_in = PROD_W'(chunk) * PROD_W'(b_ff);
            opa_in  = opa_ff << CW;
            acc_in  = (cnt_ff == '0) ? '0 : ((acc_ff << CW) + ACC_W'(prod_ff));
            if (!mul_done) cnt_in = cnt_ff + 1'b1;
         end
         nfps_pkg::ST_FUPD: begin
            avg_in = up_ff ? (avg_ff + step) : (avg_ff - step);
         end
         nfps_pkg::ST_FLOOR: begin
            if (settle_ff != '0) settle_in = settle_ff - 1'b1;
            floor_in = floor_new;
            opa_in   = OPA_W'(floor_new);
            b_in     = cfg.rel_factor;
            cnt_in   = '0;
         end
         nfps_pkg::ST_DECIDE: begin
            if (close_now) begin
               gate_in = 1'b0;
               tail_in = two_out ? (cfg.tail_length - 1'b1) : '0;
            end else if (open_now) begin
               gate_in = 1'b1;
            end else if (!gate_ff && tail_ff != '0) begin
               tail_in = tail_ff - 1'b1;
            end
         end
         default: ;
      endcase
      // rewrite of the settle count reloads the countdown
      if (cfg.load_settle) settle_in = cfg.settle_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= nfps_pkg::ST_IDLE;
         avg_ff    <= '0;
         floor_ff  <= FULL_SCALE;
         gate_ff   <= 1'b0;
         settle_ff <= nfps_pkg::SETTLE_COUNT_RST;
         tail_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         st_ff     <= st_in;
         avg_ff    <= avg_in;
         floor_ff  <= floor_in;
         gate_ff   <= gate_in;
         settle_ff <= settle_in;
         tail_ff   <= tail_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff  <= opa_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      up_ff   <= up_in;
      i_ff    <= i_in;
      q_ff    <= q_in;
   end

endmodule

@@ rtl/core/noise_floor_power_squelch.sv @@
// Top level of the noise floor power squelch: registers, queues, front and back.
// Depends on nfps_pkg, nfps_fifo, nfps_front, nfps_back and the defines header.
//
//   channel | direction | handshake          | payload
//   req     | in        | push / full        | req_in_i, req_in_q
//   rsp     | out       | pop / empty        | kind, out_i, out_q, burst_start, power_level, last
//   csr     | in        | valid / ready      | csr_index, csr_wdata
//
// The back end finishes one sample before it takes the next; the shared 24-bit chunk
// multiplier serves it once for the filter and once for the threshold, and a gate that
// closes with a tail adds a second result beat.
// Reset is synchronous; it empties both queues and reloads registers and filter state.
// The front end stalls (full) when the work queue fills; the back end waits for two free
// result slots before starting a sample, so a stalled pop never drops a result.
`include "noise_floor_power_squelch_defines.svh"

module noise_floor_power_squelch #(
   parameter int SAMPLE_BITS = nfps_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = nfps_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample input
   input  logic                                push,
   output logic                                full,
   input  logic signed [SAMPLE_BITS-1:0]       req_in_i,
   input  logic signed [SAMPLE_BITS-1:0]       req_in_q,
   // results
   output logic                                empty,
   input  logic                                pop,
   output logic                                rsp_kind,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_i,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_q,
   output logic                                rsp_burst_start,
   output logic [2*SAMPLE_BITS-1:0]            rsp_power_level,
   output logic                                rsp_last,
   // register writes
   input  logic                                valid,
   output logic                                ready,
   input  logic [nfps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nfps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int SW    = 2 * SAMPLE_BITS;
   localparam int IQ_W  = 4 * SAMPLE_BITS;
   localparam int OQ_W  = 4 * SAMPLE_BITS + 3;
   localparam int IQC_W = $clog2(nfps_pkg::IQ_DEPTH + 1);
   localparam int OQC_W = $clog2(nfps_pkg::OQ_DEPTH + 1);

   logic [nfps_pkg::ALPHA_W-1:0]  smoothing_ff, smoothing_in;
   logic [nfps_pkg::FACTOR_W-1:0] rel_factor_ff, rel_factor_in;
   logic [nfps_pkg::COUNT_W-1:0]  tail_length_ff, tail_length_in;
   logic                          wr_beat;
   nfps_pkg::cfg_type             cfg;

   logic              iq_push, iq_pop, iq_full, iq_empty;
   logic [IQ_W-1:0]   iq_wdata, iq_rdata;
   logic [IQC_W-1:0]  iq_count;
   logic              oq_push, oq_full;
   logic [OQ_W-1:0]   oq_wdata, oq_rdata;
   logic [OQC_W-1:0]  oq_count;

   // register port always takes a beat
   assign ready   = 1'b1;
   assign wr_beat = valid && ready;

   // decode register writes
   always_comb begin
      smoothing_in   = smoothing_ff;
      rel_factor_in  = rel_factor_ff;
      tail_length_in = tail_length_ff;
      if (wr_beat) begin
         case (csr_index)
            nfps_pkg::REG_SMOOTHING:   smoothing_in   = csr_wdata[nfps_pkg::ALPHA_W-1:0];
            nfps_pkg::REG_REL_FACTOR:  rel_factor_in  = csr_wdata[nfps_pkg::FACTOR_W-1:0];
            nfps_pkg::REG_TAIL_LENGTH: tail_length_in = csr_wdata[nfps_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothing_ff   <= nfps_pkg::SMOOTHING_RST;
         rel_factor_ff  <= nfps_pkg::REL_FACTOR_RST;
         tail_length_ff <= nfps_pkg::TAIL_LENGTH_RST;
      end else begin
         smoothing_ff   <= smoothing_in;
         rel_factor_ff  <= rel_factor_in;
         tail_length_ff <= tail_length_in;
      end
   end

   // settle count lives in the back end as its countdown
   always_comb begin
      cfg.smoothing    = smoothing_ff;
      cfg.rel_factor   = rel_factor_ff;
      cfg.tail_length  = tail_length_ff;
      cfg.load_settle  = wr_beat && (csr_index == nfps_pkg::REG_SETTLE_COUNT);
      cfg.settle_value = csr_wdata[nfps_pkg::COUNT_W-1:0];
   end

   nfps_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .in_i    (req_in_i),
      .in_q    (req_in_q),
      .q_full  (iq_full),
      .q_push  (iq_push),
      .q_wdata (iq_wdata)
   );

   nfps_fifo #(
      .WIDTH (IQ_W),
      .DEPTH (nfps_pkg::IQ_DEPTH)
   ) u_work_q (
      .clock (clock),
      .reset (reset),
      .push  (iq_push),
      .wdata (iq_wdata),
      .pop   (iq_pop),
      .rdata (iq_rdata),
      .full  (iq_full),
      .empty (iq_empty),
      .count (iq_count)
   );

   nfps_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .iq_empty (iq_empty),
      .iq_rdata (iq_rdata),
      .iq_pop   (iq_pop),
      .oq_count (oq_count),
      .oq_push  (oq_push),
      .oq_wdata (oq_wdata)
   );

   nfps_fifo #(
      .WIDTH (OQ_W),
      .DEPTH (nfps_pkg::OQ_DEPTH)
   ) u_result_q (
      .clock (clock),
      .reset (reset),
      .push  (oq_push),
      .wdata (oq_wdata),
      .pop   (pop),
      .rdata (oq_rdata),
      .full  (oq_full),
      .empty (empty),
      .count (oq_count)
   );

   // unpack the oldest result
   assign rsp_kind        = oq_rdata[OQ_W-1];
   assign rsp_out_i       = oq_rdata[OQ_W-2 -: SB];
   assign rsp_out_q       = oq_rdata[OQ_W-2-SB -: SB];
   assign rsp_burst_start = oq_rdata[SW+1];
   assign rsp_power_level = oq_rdata[SW:1];
   assign rsp_last        = oq_rdata[0];

   // checks
   `NFPS_ASSERT_NEVER(a_result_overflow, clock, reset, oq_push && oq_full)
   `NFPS_ASSERT_NEVER(a_work_underflow, clock, reset, iq_pop && iq_empty)
   `NFPS_ASSERT_NEXT(a_result_visible, clock, reset, oq_push, !empty)
   `NFPS_ASSERT_IMPLY(a_work_count, clock, reset, iq_full, iq_count == IQC_W'(nfps_pkg::IQ_DEPTH))

endmodule
